/* rtl/core/ppu_pkg.sv */
// Package for the particle pool update block: sizes, word and entry types,
// state codes and the saturating position update. No dependencies.
package ppu_pkg;

    localparam int POOL_SIZE = 64;
    localparam int SLOT_W    = $clog2(POOL_SIZE);
    localparam int SCAN_W    = $clog2(POOL_SIZE + 1);
    localparam int COORD_W   = 21;
    localparam int XYZ_W     = 3 * COORD_W;

    localparam logic [1:0] F_EMIT   = 2'd0;
    localparam logic [1:0] F_TICK   = 2'd1;
    localparam logic [1:0] F_KILL   = 2'd2;
    localparam logic [1:0] F_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]       func;
        logic [XYZ_W-1:0] position_xyz;
        logic [XYZ_W-1:0] velocity_xyz;
        logic [XYZ_W-1:0] crater_center_xyz;
        logic [31:0]      color_begin;
        logic [31:0]      color_end;
        logic [15:0]      lifetime;
        logic [15:0]      size_begin;
        logic [15:0]      size_end;
    } t_in_word;

    typedef struct packed {
        logic             has_particle;
        logic [XYZ_W-1:0] out_position_xyz;
        logic [15:0]      out_size;
        logic [31:0]      out_color;
        logic             is_last;
    } t_out_word;

    typedef struct packed {
        logic [XYZ_W-1:0] pos;
        logic [XYZ_W-1:0] vel;
        logic [XYZ_W-1:0] ctr;
        logic [31:0]      color_begin;
        logic [31:0]      color_end;
        logic [15:0]      total;
        logic [15:0]      left;
        logic [31:0]      size_pair;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE, S_KSCAN, S_KCHK, S_TSCAN, S_TCHK, S_BLEND, S_WB, S_FIN
    } t_state;

    typedef enum logic [1:0] {
        B_IDLE, B_DIV, B_MUL
    } t_bl_state;

    function automatic logic [XYZ_W-1:0] advance(input logic [XYZ_W-1:0] pos,
                                                 input logic [XYZ_W-1:0] vel);
        logic signed [COORD_W:0] s;
        logic [XYZ_W-1:0]        res;
        res = '0;
        for (int k = 0; k < 3; k++) begin
            s = $signed({pos[k*COORD_W+COORD_W-1], pos[k*COORD_W +: COORD_W]})
              + $signed({vel[k*COORD_W+COORD_W-1], vel[k*COORD_W +: COORD_W]});
            if (s > $signed(22'h0FFFFF)) begin
                res[k*COORD_W +: COORD_W] = 21'h0FFFFF;
            end else if (s < $signed(22'h300000)) begin
                res[k*COORD_W +: COORD_W] = 21'h100000;
            end else begin
                res[k*COORD_W +: COORD_W] = s[COORD_W-1:0];
            end
        end
        return res;
    endfunction

endpackage

/* rtl/core/particle_pool_update_top.sv */
// Particle pool update: a ring pool of particles held in one RAM entry per slot.
// An emit writes its slot straight from idle. A kill scans every slot and reads
// and checks each active one. A tick scans every slot, skipping inactive ones; a
// live particle is read, checked, blended (16-bit ratio divider, six-step shared
// multiplier) and written back once the previous result can move to the output.
// Depends on ppu_pkg, ppu_ram and ppu_blend.
module particle_pool_update_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ppu_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ppu_pkg::t_out_word o_out_word
);

    ppu_pkg::t_state                  r_state, n_state;
    logic [ppu_pkg::SCAN_W-1:0]       r_slot, n_slot;
    logic [ppu_pkg::POOL_SIZE-1:0]    r_active, n_active;
    logic [ppu_pkg::SLOT_W-1:0]       r_wslot, n_wslot;
    logic                             r_pend_v, n_pend_v;
    logic                             r_out_v, n_out_v;
    logic [ppu_pkg::XYZ_W-1:0]        r_ctr, n_ctr;
    logic [15:0]                      r_left, n_left;
    logic [ppu_pkg::XYZ_W-1:0]        r_pos, n_pos;
    ppu_pkg::t_out_word               r_pend, n_pend;
    ppu_pkg::t_out_word               r_out, n_out;

    logic                       wr_en;
    logic [ppu_pkg::SLOT_W-1:0] wr_addr;
    ppu_pkg::t_entry            wr_data;
    logic                       rd_en;
    ppu_pkg::t_entry            rd_data;
    logic                       bl_start;
    logic                       bl_done;
    logic [31:0]                bl_color;
    logic [15:0]                bl_size;
    logic                       in_acc;
    logic                       out_free;
    logic                       slot_end;
    logic [ppu_pkg::SLOT_W-1:0] idx;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_v || i_out_ready;
    assign slot_end = r_slot == ppu_pkg::SCAN_W'(ppu_pkg::POOL_SIZE);
    assign idx      = r_slot[ppu_pkg::SLOT_W-1:0];

    always_comb begin
        n_state  = r_state;
        n_slot   = r_slot;
        n_active = r_active;
        n_wslot  = r_wslot;
        n_pend_v = r_pend_v;
        n_out_v  = r_out_v && !i_out_ready;
        n_ctr    = r_ctr;
        n_left   = r_left;
        n_pos    = r_pos;
        n_pend   = r_pend;
        n_out    = r_out;
        wr_en    = 1'b0;
        wr_addr  = idx;
        wr_data  = rd_data;
        rd_en    = 1'b0;
        bl_start = 1'b0;
        case (r_state)
            ppu_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (i_in_word.func)
                        ppu_pkg::F_EMIT: begin
                            wr_en               = 1'b1;
                            wr_addr             = r_wslot;
                            wr_data.pos         = i_in_word.position_xyz;
                            wr_data.vel         = i_in_word.velocity_xyz;
                            wr_data.ctr         = i_in_word.crater_center_xyz;
                            wr_data.color_begin = i_in_word.color_begin;
                            wr_data.color_end   = i_in_word.color_end;
                            wr_data.total       = i_in_word.lifetime;
                            wr_data.left        = i_in_word.lifetime;
                            wr_data.size_pair   = {i_in_word.size_end, i_in_word.size_begin};
                            n_active[r_wslot]   = 1'b1;
                            n_wslot = (r_wslot == '0)
                                    ? ppu_pkg::SLOT_W'(ppu_pkg::POOL_SIZE - 1)
                                    : r_wslot - 1'b1;
                        end
                        ppu_pkg::F_TICK: begin
                            n_slot   = '0;
                            n_pend_v = 1'b0;
                            n_state  = ppu_pkg::S_TSCAN;
                        end
                        ppu_pkg::F_KILL: begin
                            n_ctr   = i_in_word.crater_center_xyz;
                            n_slot  = '0;
                            n_state = ppu_pkg::S_KSCAN;
                        end
                        default: n_state = ppu_pkg::S_IDLE;
                    endcase
                end
            end
            ppu_pkg::S_KSCAN: begin
                if (slot_end) begin
                    n_state = ppu_pkg::S_IDLE;
                end else if (r_active[idx]) begin
                    rd_en   = 1'b1;
                    n_state = ppu_pkg::S_KCHK;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            ppu_pkg::S_KCHK: begin
                if (rd_data.ctr == r_ctr) begin
                    n_active[idx] = 1'b0;
                end
                n_slot  = r_slot + 1'b1;
                n_state = ppu_pkg::S_KSCAN;
            end
            ppu_pkg::S_TSCAN: begin
                if (slot_end) begin
                    n_state = ppu_pkg::S_FIN;
                end else if (r_active[idx]) begin
                    rd_en   = 1'b1;
                    n_state = ppu_pkg::S_TCHK;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            ppu_pkg::S_TCHK: begin
                if (rd_data.left == 16'd0) begin
                    n_active[idx] = 1'b0;
                    n_slot        = r_slot + 1'b1;
                    n_state       = ppu_pkg::S_TSCAN;
                end else begin
                    n_left   = rd_data.left - 16'd1;
                    n_pos    = ppu_pkg::advance(rd_data.pos, rd_data.vel);
                    bl_start = 1'b1;
                    n_state  = ppu_pkg::S_BLEND;
                end
            end
            ppu_pkg::S_BLEND: begin
                if (bl_done) begin
                    n_state = ppu_pkg::S_WB;
                end
            end
            ppu_pkg::S_WB: begin
                if (!r_pend_v || out_free) begin
                    wr_en        = 1'b1;
                    wr_data.left = r_left;
                    wr_data.pos  = r_pos;
                    if (r_pend_v) begin
                        n_out   = r_pend;
                        n_out_v = 1'b1;
                    end
                    n_pend.has_particle     = 1'b1;
                    n_pend.out_position_xyz = r_pos;
                    n_pend.out_size         = bl_size;
                    n_pend.out_color        = bl_color;
                    n_pend.is_last          = 1'b0;
                    n_pend_v = 1'b1;
                    n_slot   = r_slot + 1'b1;
                    n_state  = ppu_pkg::S_TSCAN;
                end
            end
            ppu_pkg::S_FIN: begin
                if (out_free) begin
                    if (r_pend_v) begin
                        n_out         = r_pend;
                        n_out.is_last = 1'b1;
                    end else begin
                        n_out         = '0;
                        n_out.is_last = 1'b1;
                    end
                    n_out_v  = 1'b1;
                    n_pend_v = 1'b0;
                    n_state  = ppu_pkg::S_IDLE;
                end
            end
            default: n_state = ppu_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ppu_pkg::S_IDLE;
            r_slot   <= '0;
            r_active <= '0;
            r_wslot  <= ppu_pkg::SLOT_W'(ppu_pkg::POOL_SIZE - 1);
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_slot   <= n_slot;
            r_active <= n_active;
            r_wslot  <= n_wslot;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctr  <= n_ctr;
        r_left <= n_left;
        r_pos  <= n_pos;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    ppu_ram #(
        .WIDTH(ppu_pkg::ENTRY_W),
        .DEPTH(ppu_pkg::POOL_SIZE)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(idx),
        .o_rd_data(rd_data)
    );

    ppu_blend u_blend (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (bl_start),
        .i_left       (n_left),
        .i_total      (rd_data.total),
        .i_color_begin(rd_data.color_begin),
        .i_color_end  (rd_data.color_end),
        .i_size_pair  (rd_data.size_pair),
        .o_done       (bl_done),
        .o_color      (bl_color),
        .o_size       (bl_size)
    );

    assign o_in_ready  = r_state == ppu_pkg::S_IDLE;
    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out;

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.has_particle) |-> o_out_word.is_last)
        else $error("empty word without last flag");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppu_pkg::S_IDLE) |-> !r_pend_v)
        else $error("pending result left after tick");

    a_emit_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_word.func == ppu_pkg::F_EMIT) |=> r_active[$past(r_wslot)])
        else $error("emitted slot not active");

endmodule

/* rtl/core/ppu_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ppu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/ppu_blend.sv */
// Life ratio by bit-serial division, then colour, size and alpha lerps on one
// shared multiplier. Depends on ppu_pkg.
module ppu_blend (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_left,
    input  logic [15:0] i_total,
    input  logic [31:0] i_color_begin,
    input  logic [31:0] i_color_end,
    input  logic [31:0] i_size_pair,
    output logic        o_done,
    output logic [31:0] o_color,
    output logic [15:0] o_size
);

    ppu_pkg::t_bl_state r_state, n_state;
    logic [3:0]  r_cnt, n_cnt;
    logic [2:0]  r_step, n_step;
    logic        r_done, n_done;
    logic [15:0] r_rem, n_rem;
    logic [15:0] r_q, n_q;
    logic [15:0] r_total, n_total;
    logic [31:0] r_cb, n_cb;
    logic [31:0] r_ce, n_ce;
    logic [31:0] r_size, n_size;
    logic [31:0] r_color, n_color;
    logic [15:0] r_sz, n_sz;

    logic [16:0]        rem_sh;
    logic               ge;
    logic [7:0]         cb_b;
    logic [7:0]         ce_b;
    logic [15:0]        base;
    logic signed [17:0] diff;
    logic signed [34:0] prod;
    logic signed [35:0] acc;
    logic [15:0]        res16;

    always_comb begin
        rem_sh = {r_rem, 1'b0};
        ge     = rem_sh >= {1'b0, r_total};
        cb_b   = r_cb[r_step[1:0]*8 +: 8];
        ce_b   = r_ce[r_step[1:0]*8 +: 8];
        case (r_step)
            3'd0, 3'd1, 3'd2, 3'd3: begin
                base = {8'd0, ce_b};
                diff = $signed({10'd0, cb_b}) - $signed({10'd0, ce_b});
            end
            3'd4: begin
                base = r_size[31:16];
                diff = $signed({2'd0, r_size[15:0]}) - $signed({2'd0, r_size[31:16]});
            end
            default: begin
                base = '0;
                diff = $signed({10'd0, r_color[31:24]});
            end
        endcase
        prod  = diff * $signed({1'b0, r_q});
        acc   = $signed({4'd0, base, 16'd0}) + 36'(prod) + 36'sd32768;
        res16 = acc[31:16];
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_step  = r_step;
        n_done  = 1'b0;
        n_rem   = r_rem;
        n_q     = r_q;
        n_total = r_total;
        n_cb    = r_cb;
        n_ce    = r_ce;
        n_size  = r_size;
        n_color = r_color;
        n_sz    = r_sz;
        case (r_state)
            ppu_pkg::B_IDLE: begin
                if (i_start) begin
                    n_total = i_total;
                    n_cb    = i_color_begin;
                    n_ce    = i_color_end;
                    n_size  = i_size_pair;
                    n_rem   = i_left;
                    n_q     = '0;
                    n_cnt   = '0;
                    n_step  = '0;
                    if (i_total == 16'd0) begin
                        n_state = ppu_pkg::B_MUL;
                    end else if (i_left >= i_total) begin
                        n_q     = 16'hFFFF;
                        n_state = ppu_pkg::B_MUL;
                    end else begin
                        n_state = ppu_pkg::B_DIV;
                    end
                end
            end
            ppu_pkg::B_DIV: begin
                n_rem = ge ? 16'(rem_sh - {1'b0, r_total}) : rem_sh[15:0];
                n_q   = {r_q[14:0], ge};
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_state = ppu_pkg::B_MUL;
                end
            end
            ppu_pkg::B_MUL: begin
                n_step = r_step + 3'd1;
                case (r_step)
                    3'd0, 3'd1, 3'd2, 3'd3: n_color[r_step[1:0]*8 +: 8] = res16[7:0];
                    3'd4: n_sz = res16;
                    default: begin
                        n_color[31:24] = res16[7:0];
                        n_done  = 1'b1;
                        n_state = ppu_pkg::B_IDLE;
                    end
                endcase
            end
            default: n_state = ppu_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppu_pkg::B_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_q     <= n_q;
        r_total <= n_total;
        r_cb    <= n_cb;
        r_ce    <= n_ce;
        r_size  <= n_size;
        r_color <= n_color;
        r_sz    <= n_sz;
    end

    assign o_done  = r_done;
    assign o_color = r_color;
    assign o_size  = r_sz;

endmodule

/* tb/sv/tb_top.sv */
// Testbench for particle_pool_update_top: directed and random emit, tick and kill words,
// with a scoreboard that models the ring pool and checks every output word in order.
// Depends on ppu_pkg and the particle_pool_update_top RTL.
module tb_top;

    localparam int CYCLE_LIMIT = 4000000;

    class pool_scoreboard;
        bit                 active [ppu_pkg::POOL_SIZE];
        ppu_pkg::t_entry    slot [ppu_pkg::POOL_SIZE];
        int                 write_slot;
        ppu_pkg::t_out_word expected_results [$];
        int                 mismatches;
        int                 checked;

        function new();
            write_slot = ppu_pkg::POOL_SIZE - 1;
            for (int i = 0; i < ppu_pkg::POOL_SIZE; i++) begin
                active[i] = 0;
                slot[i] = '0;
            end
        endfunction

        function automatic logic [ppu_pkg::XYZ_W-1:0] step_position(
                logic [ppu_pkg::XYZ_W-1:0] p, logic [ppu_pkg::XYZ_W-1:0] v);
            logic [ppu_pkg::XYZ_W-1:0]         res;
            logic signed [ppu_pkg::COORD_W-1:0] a;
            logic signed [ppu_pkg::COORD_W-1:0] b;
            int                                 s;
            for (int k = 0; k < 3; k++) begin
                a = p[k*ppu_pkg::COORD_W +: ppu_pkg::COORD_W];
                b = v[k*ppu_pkg::COORD_W +: ppu_pkg::COORD_W];
                s = int'(a) + int'(b);
                if (s > 1048575) s = 1048575;
                if (s < -1048576) s = -1048576;
                res[k*ppu_pkg::COORD_W +: ppu_pkg::COORD_W] = s[ppu_pkg::COORD_W-1:0];
            end
            return res;
        endfunction

        function automatic int unsigned lerp(int unsigned e, int unsigned b, int unsigned r);
            longint unsigned acc;
            acc = longint'(e) * (65536 - r) + longint'(b) * r + 32768;
            return int'(acc >> 16);
        endfunction

        function void predict_tick();
            ppu_pkg::t_out_word o;
            int unsigned        r;
            int unsigned        v;
            int                 n;
            n = 0;
            for (int i = 0; i < ppu_pkg::POOL_SIZE; i++) begin
                if (!active[i]) continue;
                if (slot[i].left == 0) begin
                    active[i] = 0;
                    continue;
                end
                slot[i].left = 16'(slot[i].left - 1);
                slot[i].pos = step_position(slot[i].pos, slot[i].vel);
                if (slot[i].total == 0) r = 0;
                else if (slot[i].left >= slot[i].total) r = 65535;
                else r = int'((longint'(slot[i].left) << 16) / slot[i].total);
                o = '0;
                o.has_particle = 1'b1;
                o.out_position_xyz = slot[i].pos;
                o.out_size = 16'(lerp(32'(slot[i].size_pair[31:16]),
                                      32'(slot[i].size_pair[15:0]), r));
                for (int ch = 0; ch < 4; ch++) begin
                    v = lerp(32'(slot[i].color_end[8*ch +: 8]),
                             32'(slot[i].color_begin[8*ch +: 8]), r);
                    if (ch == 3) v = int'((longint'(v) * r + 32768) >> 16);
                    o.out_color[8*ch +: 8] = v[7:0];
                end
                expected_results.push_back(o);
                n++;
            end
            if (n == 0) begin
                o = '0;
                o.is_last = 1'b1;
                expected_results.push_back(o);
            end else begin
                expected_results[expected_results.size()-1].is_last = 1'b1;
            end
        endfunction

        function void note_word(ppu_pkg::t_in_word w);
            case (w.func)
                ppu_pkg::F_EMIT: begin
                    active[write_slot] = 1;
                    slot[write_slot].pos = w.position_xyz;
                    slot[write_slot].vel = w.velocity_xyz;
                    slot[write_slot].ctr = w.crater_center_xyz;
                    slot[write_slot].color_begin = w.color_begin;
                    slot[write_slot].color_end = w.color_end;
                    slot[write_slot].total = w.lifetime;
                    slot[write_slot].left = w.lifetime;
                    slot[write_slot].size_pair = {w.size_end, w.size_begin};
                    write_slot = (write_slot == 0) ? ppu_pkg::POOL_SIZE - 1 : write_slot - 1;
                end
                ppu_pkg::F_KILL: begin
                    for (int i = 0; i < ppu_pkg::POOL_SIZE; i++)
                        if (active[i] && slot[i].ctr == w.crater_center_xyz) active[i] = 0;
                end
                ppu_pkg::F_TICK: predict_tick();
                default: ;
            endcase
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch on %s at word %0d: got %h, expected %h",
                     what, checked, got, want);
            mismatches++;
        endtask

        task check_word(ppu_pkg::t_out_word got);
            ppu_pkg::t_out_word want;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected word", 64'(got.out_color), 64'd0);
            end else begin
                want = expected_results.pop_front();
                if (got.has_particle !== want.has_particle)
                    report_mismatch("has_particle", 64'(got.has_particle),
                                    64'(want.has_particle));
                if (got.out_position_xyz !== want.out_position_xyz)
                    report_mismatch("position", 64'(got.out_position_xyz),
                                    64'(want.out_position_xyz));
                if (got.out_size !== want.out_size)
                    report_mismatch("size", 64'(got.out_size), 64'(want.out_size));
                if (got.out_color !== want.out_color)
                    report_mismatch("colour", 64'(got.out_color), 64'(want.out_color));
                if (got.is_last !== want.is_last)
                    report_mismatch("is_last", 64'(got.is_last), 64'(want.is_last));
            end
            checked++;
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    ppu_pkg::t_in_word  i_in_word;
    logic               o_out_valid;
    logic               i_out_ready;
    ppu_pkg::t_out_word o_out_word;

    pool_scoreboard pool_sb;
    bit             no_idle;
    int             cycles;
    int             emits, ticks, kills;
    logic [ppu_pkg::XYZ_W-1:0] centres [4];

    particle_pool_update_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d words outstanding", pool_sb.expected_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) i_out_ready <= no_idle || ($urandom_range(99) >= 6);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) pool_sb.check_word(o_out_word);
    end

    function automatic logic [ppu_pkg::XYZ_W-1:0] any_xyz();
        return ppu_pkg::XYZ_W'({$urandom, $urandom});
    endfunction

    task send_word(ppu_pkg::t_in_word w);
        if (!no_idle && $urandom_range(99) < 6) begin
            i_in_valid = 0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_in_valid = 1;
        i_in_word = w;
        do @(posedge i_clk); while (!o_in_ready);
        pool_sb.note_word(w);
        case (w.func)
            ppu_pkg::F_EMIT: emits++;
            ppu_pkg::F_TICK: ticks++;
            ppu_pkg::F_KILL: kills++;
            default: ;
        endcase
        @(negedge i_clk);
        i_in_valid = 0;
    endtask

    function automatic ppu_pkg::t_in_word emit_word(logic [15:0] life);
        ppu_pkg::t_in_word w;
        w.func = ppu_pkg::F_EMIT;
        w.position_xyz = any_xyz();
        w.velocity_xyz = any_xyz();
        w.crater_center_xyz = ($urandom_range(3) == 0) ? any_xyz() : centres[$urandom_range(3)];
        w.color_begin = $urandom;
        w.color_end = $urandom;
        w.lifetime = life;
        w.size_begin = 16'($urandom);
        w.size_end = 16'($urandom);
        return w;
    endfunction

    function automatic ppu_pkg::t_in_word op_word(logic [1:0] f);
        ppu_pkg::t_in_word w;
        w = emit_word(16'd0);
        w.func = f;
        return w;
    endfunction

    task drain();
        while (pool_sb.expected_results.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        ppu_pkg::t_in_word w;
        int                pick;
        pool_sb = new();
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_word = '0;
        i_out_ready = 0;
        for (int k = 0; k < 4; k++) centres[k] = any_xyz();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1;

        // empty pool, unused func, extreme fields
        send_word(op_word(ppu_pkg::F_TICK));
        send_word(op_word(ppu_pkg::F_UNUSED));
        w = emit_word(16'hFFFF);
        w.position_xyz = {3{21'h0FFFFF}};
        w.velocity_xyz = {3{21'h0FFFFF}};
        w.color_begin = '1; w.color_end = '0; w.size_begin = '1; w.size_end = '0;
        send_word(w);
        w = emit_word(16'd1);
        w.position_xyz = {3{21'h100000}};
        w.velocity_xyz = {3{21'h100000}};
        w.color_begin = '0; w.color_end = '1; w.size_begin = '0; w.size_end = '1;
        send_word(w);
        send_word(emit_word(16'd0));
        w = emit_word(16'd2);
        w.crater_center_xyz = '1;
        send_word(w);
        send_word(emit_word(16'h8000));
        repeat (3) send_word(op_word(ppu_pkg::F_TICK));
        w = op_word(ppu_pkg::F_KILL);
        w.crater_center_xyz = '1;
        send_word(w);
        send_word(w);
        w.crater_center_xyz = '0;
        send_word(w);
        send_word(op_word(ppu_pkg::F_TICK));

        for (int n = 0; n < 450; n++) begin
            no_idle = (n >= 150 && n < 260);
            if (n == 320) drain();
            pick = $urandom_range(99);
            if (pick < 50) begin
                pick = $urandom_range(19);
                send_word(emit_word(pick < 2 ? 16'd0 : pick < 4 ? 16'($urandom)
                                               : 16'($urandom_range(1, 6))));
            end else if (pick < 85) begin
                send_word(op_word(ppu_pkg::F_TICK));
            end else if (pick < 97) begin
                w = op_word(ppu_pkg::F_KILL);
                if ($urandom_range(3) != 0) w.crater_center_xyz = centres[$urandom_range(3)];
                send_word(w);
            end else begin
                send_word(op_word(ppu_pkg::F_UNUSED));
            end
        end
        no_idle = 0;
        i_in_valid = 0;
        drain();
        repeat (2000) @(negedge i_clk);

        $display("sent %0d emits, %0d ticks and %0d kills; checked %0d output words",
                 emits, ticks, kills, pool_sb.checked);
        if (pool_sb.mismatches == 0 && pool_sb.expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d failures, %0d words still expected", pool_sb.mismatches,
                     pool_sb.expected_results.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/core/ppu_pkg.sv
rtl/core/ppu_ram.sv
rtl/core/ppu_blend.sv
rtl/core/particle_pool_update_top.sv
tb/sv/tb_top.sv
